[rtl/team_grouped_fifo_unit_assert.svh]
// ----------------------------------------------------------------------------
// Team queue assertion macros
// Property shorthands for the team queue checks; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef TEAM_GROUPED_FIFO_UNIT_ASSERT_SVH
`define TEAM_GROUPED_FIFO_UNIT_ASSERT_SVH

// Invariant that holds at every clock edge out of reset.
`define TGF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define TGF_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/tgf_pkg.sv]
// ----------------------------------------------------------------------------
// Team queue package
// Sizes, operation and status codes and the controller state type.
// ----------------------------------------------------------------------------
package tgf_pkg;

  localparam int ELEMENT_BITS = 10;
  localparam int TEAM_COUNT   = 16;   // power of two: team order ring wraps naturally
  localparam int QUEUE_DEPTH  = 256;  // power of two: node index wraps naturally

  localparam int ELEM_COUNT     = 1 << ELEMENT_BITS;
  localparam int TEAM_BITS      = $clog2(TEAM_COUNT);
  localparam int MARK_BITS      = $clog2(TEAM_COUNT + 1);
  localparam int NODE_BITS      = $clog2(QUEUE_DEPTH);
  localparam int FREE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int ORDER_CNT_BITS = $clog2(TEAM_COUNT + 1);
  localparam int KIND_BITS      = 2;
  localparam int STATUS_BITS    = 3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ASSIGN  = 2'd0,
    KIND_ENQUEUE = 2'd1,
    KIND_DEQUEUE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_DEQUEUED = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ENQ_TEAM,
    S_ENQ_WR,
    S_DEQ_TEAM,
    S_DEQ_NODE,
    S_DEQ_WR,
    S_DONE
  } state_t;

endpackage

[rtl/team_grouped_fifo_unit.sv]
// Team queue (grouped FIFO). One transaction in gives one result out. Items are
// handled one at a time by a controller around six single-port-read memories
// with registered reads; dependent reads set the time per item: an enqueue
// reads membership (unknown or full ends there), then the team table, then
// writes back; a dequeue reads the order ring, the team table and the node,
// then writes back; assign, unused kinds and a dequeue on an empty queue need
// no read. A new item is taken while the previous result still sits in the
// output register; a new result is held back only if the previous one has
// not been taken. After reset a clearing pass empties the membership table
// and fills the free node list; no input is taken during it.
// ----------------------------------------------------------------------------
// team_grouped_fifo_unit
// Team queue controller with membership, node, free list, team and order RAMs.
// ----------------------------------------------------------------------------
module team_grouped_fifo_unit
  import tgf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [KIND_BITS-1:0]    in_kind,
  input  logic [ELEMENT_BITS-1:0] in_element_id,
  input  logic [TEAM_BITS-1:0]    in_team_id,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_BITS-1:0]  out_status,
  output logic [ELEMENT_BITS-1:0] out_element_out
);

  localparam logic [ELEMENT_BITS:0] DEPTH_EXT = (ELEMENT_BITS + 1)'(QUEUE_DEPTH);

  // memories
  logic [MARK_BITS-1:0]    toe_mem   [ELEM_COUNT];
  logic [NODE_BITS-1:0]    free_mem  [QUEUE_DEPTH];
  logic [ELEMENT_BITS-1:0] nelem_mem [QUEUE_DEPTH];
  logic [NODE_BITS-1:0]    nlink_mem [QUEUE_DEPTH];
  logic [2*NODE_BITS-1:0]  team_mem  [TEAM_COUNT];   // {first, last}
  logic [TEAM_BITS-1:0]    order_mem [TEAM_COUNT];

  // memory ports
  logic                    toe_we, toe_re;
  logic [ELEMENT_BITS-1:0] toe_waddr;
  logic [MARK_BITS-1:0]    toe_wdata, toe_rdata_r;
  logic                    free_we, free_re;
  logic [NODE_BITS-1:0]    free_waddr, free_raddr, free_wdata, free_rdata_r;
  logic                    node_re, nelem_we, nlink_we;
  logic [NODE_BITS-1:0]    node_raddr, nelem_waddr, nlink_waddr, nlink_wdata;
  logic [ELEMENT_BITS-1:0] nelem_rdata_r;
  logic [NODE_BITS-1:0]    nlink_rdata_r;
  logic                    team_we, team_re;
  logic [TEAM_BITS-1:0]    team_waddr, team_raddr;
  logic [2*NODE_BITS-1:0]  team_wdata, team_rdata_r;
  logic                    order_we, order_re;
  logic [TEAM_BITS-1:0]    order_waddr, order_wdata, order_rdata_r;

  // control and payload registers
  state_t                  state_r, state_nxt;
  logic [ELEMENT_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic [FREE_CNT_BITS-1:0]  free_count_r, free_count_nxt;
  logic [TEAM_BITS-1:0]      order_front_r, order_front_nxt;
  logic [ORDER_CNT_BITS-1:0] order_count_r, order_count_nxt;
  logic [TEAM_COUNT-1:0]     waiting_r, waiting_nxt;
  logic [ELEMENT_BITS-1:0]   elem_r, elem_nxt;
  logic [TEAM_BITS-1:0]      team_r, team_nxt;
  status_t                   pend_status_r, pend_status_nxt;
  logic                      out_valid_r, out_valid_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [ELEMENT_BITS-1:0]   out_element_r, out_element_nxt;

  logic                  out_free;
  logic [MARK_BITS-1:0]  mark_dec;
  logic [NODE_BITS-1:0]  first_rd, last_rd;

  assign out_free = !out_valid_r || !out_stall;
  assign mark_dec = toe_rdata_r - MARK_BITS'(1);
  assign first_rd = team_rdata_r[2*NODE_BITS-1:NODE_BITS];
  assign last_rd  = team_rdata_r[NODE_BITS-1:0];

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element_out = out_element_r;

  always_comb begin
    state_nxt       = state_r;
    clr_idx_nxt     = clr_idx_r;
    free_count_nxt  = free_count_r;
    order_front_nxt = order_front_r;
    order_count_nxt = order_count_r;
    waiting_nxt     = waiting_r;
    elem_nxt        = elem_r;
    team_nxt        = team_r;
    pend_status_nxt = pend_status_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = out_status_r;
    out_element_nxt = out_element_r;

    toe_we      = 1'b0;
    toe_re      = 1'b0;
    toe_waddr   = in_element_id;
    toe_wdata   = MARK_BITS'(in_team_id) + MARK_BITS'(1);
    free_we     = 1'b0;
    free_re     = 1'b0;
    free_waddr  = free_count_r[NODE_BITS-1:0];
    free_raddr  = NODE_BITS'(free_count_r - FREE_CNT_BITS'(1));
    free_wdata  = first_rd;
    node_re     = 1'b0;
    node_raddr  = first_rd;
    nelem_we    = 1'b0;
    nelem_waddr = free_rdata_r;
    nlink_we    = 1'b0;
    nlink_waddr = last_rd;
    nlink_wdata = free_rdata_r;
    team_we     = 1'b0;
    team_re     = 1'b0;
    team_waddr  = team_r;
    team_raddr  = mark_dec[TEAM_BITS-1:0];
    team_wdata  = {free_rdata_r, free_rdata_r};
    order_we    = 1'b0;
    order_re    = 1'b0;
    order_waddr = order_front_r + order_count_r[TEAM_BITS-1:0];
    order_wdata = team_r;

    case (state_r)
      S_CLEAR: begin
        // wipe membership, load free list with every node index
        toe_we    = 1'b1;
        toe_waddr = clr_idx_r;
        toe_wdata = '0;
        if ({1'b0, clr_idx_r} < DEPTH_EXT) begin
          free_we    = 1'b1;
          free_waddr = clr_idx_r[NODE_BITS-1:0];
          free_wdata = clr_idx_r[NODE_BITS-1:0];
        end
        clr_idx_nxt = clr_idx_r + ELEMENT_BITS'(1);
        if (clr_idx_r == ELEMENT_BITS'(ELEM_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          elem_nxt = in_element_id;
          case (kind_t'(in_kind))
            KIND_ASSIGN: begin
              toe_we          = 1'b1;
              pend_status_nxt = ST_ACCEPTED;
              state_nxt       = S_DONE;
            end
            KIND_ENQUEUE: begin
              toe_re    = 1'b1;
              free_re   = 1'b1;
              state_nxt = S_ENQ_TEAM;
            end
            KIND_DEQUEUE: begin
              if (order_count_r == '0) begin
                pend_status_nxt = ST_EMPTY;
                state_nxt       = S_DONE;
              end else begin
                order_re  = 1'b1;
                state_nxt = S_DEQ_TEAM;
              end
            end
            default: begin
              pend_status_nxt = ST_ACCEPTED;
              state_nxt       = S_DONE;
            end
          endcase
        end
      end
      S_ENQ_TEAM: begin
        if (toe_rdata_r == '0) begin
          pend_status_nxt = ST_UNKNOWN;
          state_nxt       = S_DONE;
        end else if (free_count_r == '0) begin
          pend_status_nxt = ST_FULL;
          state_nxt       = S_DONE;
        end else begin
          team_nxt  = mark_dec[TEAM_BITS-1:0];
          team_re   = 1'b1;
          state_nxt = S_ENQ_WR;
        end
      end
      S_ENQ_WR: begin
        if (out_free) begin
          nelem_we = 1'b1;
          team_we  = 1'b1;
          if (waiting_r[team_r]) begin
            // append behind the team's last waiting member
            nlink_we   = 1'b1;
            team_wdata = {first_rd, free_rdata_r};
          end else begin
            waiting_nxt[team_r] = 1'b1;
            if (order_count_r < ORDER_CNT_BITS'(TEAM_COUNT)) begin
              order_we        = 1'b1;
              order_count_nxt = order_count_r + ORDER_CNT_BITS'(1);
            end
          end
          free_count_nxt  = free_count_r - FREE_CNT_BITS'(1);
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_ACCEPTED;
          out_element_nxt = '0;
          state_nxt       = S_IDLE;
        end
      end
      S_DEQ_TEAM: begin
        team_nxt   = order_rdata_r;
        team_re    = 1'b1;
        team_raddr = order_rdata_r;
        state_nxt  = S_DEQ_NODE;
      end
      S_DEQ_NODE: begin
        node_re   = 1'b1;
        state_nxt = S_DEQ_WR;
      end
      S_DEQ_WR: begin
        if (out_free) begin
          if (first_rd == last_rd) begin
            // team's last member leaves: drop team from the order ring
            waiting_nxt[team_r] = 1'b0;
            order_front_nxt     = order_front_r + TEAM_BITS'(1);
            order_count_nxt     = order_count_r - ORDER_CNT_BITS'(1);
          end else begin
            team_we    = 1'b1;
            team_wdata = {nlink_rdata_r, last_rd};
          end
          if (free_count_r < FREE_CNT_BITS'(QUEUE_DEPTH)) begin
            free_we        = 1'b1;
            free_count_nxt = free_count_r + FREE_CNT_BITS'(1);
          end
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_DEQUEUED;
          out_element_nxt = nelem_rdata_r;
          state_nxt       = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = pend_status_r;
          out_element_nxt = '0;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_idx_r     <= '0;
      free_count_r  <= FREE_CNT_BITS'(QUEUE_DEPTH);
      order_front_r <= '0;
      order_count_r <= '0;
      waiting_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_idx_r     <= clr_idx_nxt;
      free_count_r  <= free_count_nxt;
      order_front_r <= order_front_nxt;
      order_count_r <= order_count_nxt;
      waiting_r     <= waiting_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    elem_r        <= elem_nxt;
    team_r        <= team_nxt;
    pend_status_r <= pend_status_nxt;
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
  end

  // membership table
  always_ff @(posedge clk) begin
    if (toe_we) begin
      toe_mem[toe_waddr] <= toe_wdata;
    end
    if (toe_re) begin
      toe_rdata_r <= toe_mem[in_element_id];
    end
  end

  // free node stack
  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_waddr] <= free_wdata;
    end
    if (free_re) begin
      free_rdata_r <= free_mem[free_raddr];
    end
  end

  // node element and link
  always_ff @(posedge clk) begin
    if (nelem_we) begin
      nelem_mem[nelem_waddr] <= elem_r;
    end
    if (node_re) begin
      nelem_rdata_r <= nelem_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (nlink_we) begin
      nlink_mem[nlink_waddr] <= nlink_wdata;
    end
    if (node_re) begin
      nlink_rdata_r <= nlink_mem[node_raddr];
    end
  end

  // per-team first and last node
  always_ff @(posedge clk) begin
    if (team_we) begin
      team_mem[team_waddr] <= team_wdata;
    end
    if (team_re) begin
      team_rdata_r <= team_mem[team_raddr];
    end
  end

  // ring of waiting teams
  always_ff @(posedge clk) begin
    if (order_we) begin
      order_mem[order_waddr] <= order_wdata;
    end
    if (order_re) begin
      order_rdata_r <= order_mem[order_front_r];
    end
  end

`include "team_grouped_fifo_unit_assert.svh"

  `TGF_ASSERT_ALWAYS(a_order_matches_waiting,
                     order_count_r == ORDER_CNT_BITS'($countones(waiting_r)),
                     "order ring count differs from waiting teams")
  `TGF_ASSERT_ALWAYS(a_free_count_range,
                     free_count_r <= FREE_CNT_BITS'(QUEUE_DEPTH),
                     "free count above pool size")
  `TGF_ASSERT_IMPLY(a_elem_zero,
                    out_valid_r && (out_status_r != ST_DEQUEUED),
                    out_element_r == '0,
                    "element nonzero on non-dequeue result")

endmodule

[tb/team_queue_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Team queue checker
// Watches both channels of the team queue, predicts every result from its own
// copy of the membership table, node pool, team lists and team order ring, and
// compares each result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module team_queue_checker
  import tgf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [KIND_BITS-1:0]    in_kind,
  input  logic [ELEMENT_BITS-1:0] in_element_id,
  input  logic [TEAM_BITS-1:0]    in_team_id,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [STATUS_BITS-1:0]  out_status,
  input  logic [ELEMENT_BITS-1:0] out_element_out,
  output int                      fail_count,
  output int                      pending_count,
  output int                      checked_count,
  output int                      dequeued_count,
  output int                      unknown_count,
  output int                      full_count,
  output int                      empty_count
);

  typedef struct packed {
    status_t                 status;
    logic [ELEMENT_BITS-1:0] element;
  } outcome_t;

  // predicted queue state
  logic [MARK_BITS-1:0]      team_mark   [ELEM_COUNT];  // 0: no team, else team + 1
  logic [ELEMENT_BITS-1:0]   slot_elem   [QUEUE_DEPTH];
  logic [NODE_BITS-1:0]      slot_next   [QUEUE_DEPTH];
  logic [NODE_BITS-1:0]      spare_slots [QUEUE_DEPTH];
  logic [FREE_CNT_BITS-1:0]  spare_cnt;
  logic [NODE_BITS-1:0]      grp_head    [TEAM_COUNT];
  logic [NODE_BITS-1:0]      grp_tail    [TEAM_COUNT];
  logic [TEAM_COUNT-1:0]     grp_live;
  logic [TEAM_BITS-1:0]      ring        [TEAM_COUNT];
  logic [TEAM_BITS-1:0]      ring_head;
  logic [ORDER_CNT_BITS-1:0] ring_len;

  outcome_t pending_outcomes [$];

  int errors    = 0;
  int checked   = 0;
  int n_deq     = 0;
  int n_unknown = 0;
  int n_full    = 0;
  int n_empty   = 0;

  task automatic clear_queue_state();
    for (int i = 0; i < ELEM_COUNT; i++) team_mark[i] = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) spare_slots[i] = NODE_BITS'(i);
    spare_cnt = FREE_CNT_BITS'(QUEUE_DEPTH);
    grp_live  = '0;
    ring_head = '0;
    ring_len  = '0;
  endtask

  task automatic team_queue_step(
    input  logic [KIND_BITS-1:0]    kind,
    input  logic [ELEMENT_BITS-1:0] elem,
    input  logic [TEAM_BITS-1:0]    team_in,
    output outcome_t                res
  );
    logic [MARK_BITS-1:0] mark;
    logic [TEAM_BITS-1:0] team;
    logic [TEAM_BITS-1:0] ring_pos;
    logic [NODE_BITS-1:0] node;
    res.status  = ST_ACCEPTED;
    res.element = '0;
    case (kind)
      KIND_ASSIGN: begin
        team_mark[elem] = MARK_BITS'(team_in) + 1'b1;
      end
      KIND_ENQUEUE: begin
        mark = team_mark[elem];
        if (mark == '0) begin
          res.status = ST_UNKNOWN;
        end else if (spare_cnt == '0) begin
          res.status = ST_FULL;
        end else begin
          team      = TEAM_BITS'(mark - 1'b1);
          spare_cnt = spare_cnt - 1'b1;
          node      = spare_slots[spare_cnt];
          slot_elem[node] = elem;
          slot_next[node] = node;
          if (grp_live[team]) begin
            slot_next[grp_tail[team]] = node;
            grp_tail[team] = node;
          end else begin
            grp_head[team] = node;
            grp_tail[team] = node;
            grp_live[team] = 1'b1;
            if (ring_len < TEAM_COUNT) begin
              ring_pos       = TEAM_BITS'(ring_head + ring_len);
              ring[ring_pos] = team;
              ring_len       = ring_len + 1'b1;
            end
          end
        end
      end
      KIND_DEQUEUE: begin
        if (ring_len == '0) begin
          res.status = ST_EMPTY;
        end else begin
          team        = ring[ring_head];
          node        = grp_head[team];
          res.status  = ST_DEQUEUED;
          res.element = slot_elem[node];
          // last waiting member leaves: the team drops out of the order ring
          if (node == grp_tail[team]) begin
            grp_live[team] = 1'b0;
            ring_head      = ring_head + 1'b1;
            ring_len       = ring_len - 1'b1;
          end else begin
            grp_head[team] = slot_next[node];
          end
          if (spare_cnt < QUEUE_DEPTH) begin
            spare_slots[spare_cnt] = node;
            spare_cnt = spare_cnt + 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    outcome_t want;
    outcome_t got;
    if (!rst_n) begin
      clear_queue_state();
      pending_outcomes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with no transaction waiting: status %0d element %0d",
                                    out_status, out_element_out));
        end else begin
          want = pending_outcomes.pop_front();
          checked++;
          case (want.status)
            ST_DEQUEUED: n_deq++;
            ST_UNKNOWN:  n_unknown++;
            ST_FULL:     n_full++;
            ST_EMPTY:    n_empty++;
            default: ;
          endcase
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                      out_status, want.status, want.status.name()));
          if (out_element_out !== want.element)
            report_mismatch($sformatf("element_out %0d, expected %0d (status %s)",
                                      out_element_out, want.element, want.status.name()));
        end
      end
      if (in_valid && !in_stall) begin
        team_queue_step(in_kind, in_element_id, in_team_id, got);
        pending_outcomes.push_back(got);
      end
    end
    fail_count     <= errors;
    pending_count  <= pending_outcomes.size();
    checked_count  <= checked;
    dequeued_count <= n_deq;
    unknown_count  <= n_unknown;
    full_count     <= n_full;
    empty_count    <= n_empty;
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Team queue testbench top
// Drives directed and random assign / enqueue / dequeue traffic into the team
// queue under changing backpressure; the checker beside the block predicts
// and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
  import tgf_pkg::*;
;

  localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;  // unused kind, no effect
  localparam int POOL_SIZE    = 64;                      // elements assigned up front
  localparam int FILL_ITEMS   = 420;
  localparam int DRAIN_ITEMS  = 380;
  localparam int MIXED_ITEMS  = 386;

  logic                    clk           = 1'b0;
  logic                    rst_n         = 1'b0;
  logic                    in_valid      = 1'b0;
  logic [KIND_BITS-1:0]    in_kind       = '0;
  logic [ELEMENT_BITS-1:0] in_element_id = '0;
  logic [TEAM_BITS-1:0]    in_team_id    = '0;
  logic                    out_stall     = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic [STATUS_BITS-1:0]  out_status;
  logic [ELEMENT_BITS-1:0] out_element_out;

  int fail_count, pending_count, checked_count;
  int dequeued_count, unknown_count, full_count, empty_count;

  int sent_count     = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  team_grouped_fifo_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_element_id  (in_element_id),
    .in_team_id     (in_team_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_element_out(out_element_out)
  );

  team_queue_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_element_id  (in_element_id),
    .in_team_id     (in_team_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_element_out(out_element_out),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count),
    .dequeued_count (dequeued_count),
    .unknown_count  (unknown_count),
    .full_count     (full_count),
    .empty_count    (empty_count)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // one transaction; backpressure mode rotates every 100 transactions
  task automatic send_item(
    input logic [KIND_BITS-1:0]    kind,
    input logic [ELEMENT_BITS-1:0] elem,
    input logic [TEAM_BITS-1:0]    team
  );
    case ((sent_count / 100) % 4)
      0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1:       begin src_idle_pct = 60; sink_stall_pct = 0;  end
      2:       begin src_idle_pct = 0;  sink_stall_pct = 60; end
      default: begin src_idle_pct = 10; sink_stall_pct = 10; end
    endcase
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_element_id <= elem;
    in_team_id    <= team;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // mostly members of the assigned pool, sometimes anything (often unknown)
  function automatic logic [ELEMENT_BITS-1:0] pick_element();
    if ($urandom_range(0, 99) < 90)
      return ELEMENT_BITS'($urandom_range(0, POOL_SIZE - 1));
    return ELEMENT_BITS'($urandom_range(0, ELEM_COUNT - 1));
  endfunction

  task automatic random_item(input int enq_pct, input int deq_pct, input int asg_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < enq_pct)
      send_item(KIND_ENQUEUE, pick_element(), TEAM_BITS'($urandom));
    else if (r < enq_pct + deq_pct)
      send_item(KIND_DEQUEUE, ELEMENT_BITS'($urandom), TEAM_BITS'($urandom));
    else if (r < enq_pct + deq_pct + asg_pct)
      send_item(KIND_ASSIGN, pick_element(), TEAM_BITS'($urandom));
    else
      send_item(KIND_SPARE, ELEMENT_BITS'($urandom), TEAM_BITS'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty and unknown first, then grouping, reassignment, unused kind
    send_item(KIND_DEQUEUE, 10'h3ff, 4'hf);
    send_item(KIND_ENQUEUE, 10'h000, 4'h0);
    send_item(KIND_ENQUEUE, 10'h3ff, 4'hf);
    send_item(KIND_ASSIGN,  10'h000, 4'h0);
    send_item(KIND_ASSIGN,  10'h3ff, 4'hf);
    send_item(KIND_ASSIGN,  10'h155, 4'h5);
    send_item(KIND_ASSIGN,  10'h2aa, 4'ha);
    send_item(KIND_ASSIGN,  10'h001, 4'h0);
    send_item(KIND_ENQUEUE, 10'h000, 4'h0);
    send_item(KIND_ENQUEUE, 10'h3ff, 4'h0);
    send_item(KIND_ENQUEUE, 10'h155, 4'h0);
    send_item(KIND_ENQUEUE, 10'h001, 4'hf);
    send_item(KIND_ASSIGN,  10'h000, 4'hf);
    send_item(KIND_ENQUEUE, 10'h000, 4'h0);
    send_item(KIND_SPARE,   10'h3ff, 4'hf);
    send_item(KIND_SPARE,   10'h000, 4'h0);
    send_item(KIND_ENQUEUE, 10'h2aa, 4'h5);
    repeat (6) send_item(KIND_DEQUEUE, 10'h000, 4'h0);
    send_item(KIND_DEQUEUE, 10'h155, 4'ha);

    // random: assign the pool, fill past full, drain past empty, then mix
    for (int i = 0; i < POOL_SIZE; i++)
      send_item(KIND_ASSIGN, ELEMENT_BITS'(i), TEAM_BITS'($urandom));
    repeat (FILL_ITEMS)  random_item(90, 5, 4);
    repeat (DRAIN_ITEMS) random_item(10, 85, 4);
    repeat (MIXED_ITEMS) random_item(45, 45, 7);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d transactions (directed, queue fill, drain, mixed)", sent_count);
    $display("  under four backpressure modes");
    $display("Checked %0d results: %0d dequeued, %0d unknown, %0d full, %0d empty",
             checked_count, dequeued_count, unknown_count, full_count, empty_count);
    if (fail_count == 0)
      $display("team_grouped_fifo_unit verification clean");
    else
      $display("team_grouped_fifo_unit verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: results still outstanding");
    $display("team_grouped_fifo_unit verification failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/tgf_pkg.sv
rtl/team_grouped_fifo_unit.sv
tb/team_queue_checker.sv
tb/tb_top.sv
